### rtl/core/image_crop_mirror_normalize_unit_assert.svh
// Assertion macros used by the back part of the image crop, mirror and normalize RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef IMAGE_CROP_MIRROR_NORMALIZE_UNIT_ASSERT_SVH
`define IMAGE_CROP_MIRROR_NORMALIZE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ICMN_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icmn assertion failed");

// Next-cycle implication, checked outside reset.
`define ICMN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icmn assertion failed");

`endif

### rtl/core/icmn_pkg.sv
// Shared types and codes for the image crop, mirror and normalize unit.
// Used by the front, queue, back and top-level modules; depends on nothing.
package icmn_pkg;

    localparam int CROP_W  = 9;
    localparam int OFF_W   = 10;
    localparam int SCALE_W = 24;
    localparam int MEANS_W = 48;
    localparam int MEAN_W  = 16;
    localparam int PIX_W   = 8;
    localparam int CH_W    = 2;
    localparam int IDX_W   = 18;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int REG_IDX_W = 3;

    localparam logic [MODE_W-1:0] MEAN_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MEAN_CHANNEL = 2'd1;
    localparam logic [MODE_W-1:0] MEAN_ELEMENT = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CROP_HEIGHT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CROP_WIDTH    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW_OFFSET    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_COL_OFFSET    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIRROR        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MEAN_MODE     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SCALE         = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CHANNEL_MEANS = 3'd7;

    typedef struct packed {
        logic [CROP_W-1:0]  height;
        logic [CROP_W-1:0]  width;
        logic [OFF_W-1:0]   row_off;
        logic [OFF_W-1:0]   col_off;
        logic               mirror;
        logic [MODE_W-1:0]  mean_mode;
        logic [SCALE_W-1:0] scale;
        logic [MEANS_W-1:0] means;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic [MEAN_W-1:0] mean;
        logic [CH_W-1:0]   ch;
        logic [CROP_W-1:0] row;
        logic [CROP_W-1:0] col;
    } t_entry;

endpackage

### rtl/core/icmn_front.sv
// Front part: accepts pixel transfers, tracks row, column and channel, and
// queues kept pixels with their crop position and mean. Depends on icmn_pkg.
module icmn_front #(
    parameter int CHANNELS  = 3,
    parameter int MAX_IMAGE = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  icmn_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [icmn_pkg::PIX_W-1:0] i_pixel,
    input  logic                       i_frame_start,
    input  logic                       i_row_end,
    input  logic [icmn_pkg::MEAN_W-1:0] i_pixel_mean,
    input  logic                       i_full,
    output logic                       o_push,
    output icmn_pkg::t_entry           o_entry
);

    localparam int CW = $clog2(MAX_IMAGE);
    localparam int DW = ((CW > icmn_pkg::OFF_W) ? CW : icmn_pkg::OFF_W) + 1;

    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [icmn_pkg::CH_W-1:0] r_ch, n_ch;

    logic [CW-1:0] cur_row, cur_col;
    logic [icmn_pkg::CH_W-1:0] cur_ch, ch_inc;
    logic [DW-1:0] row_d, col_d;
    logic row_hit, col_hit, accept;
    logic [icmn_pkg::CROP_W-1:0] w_pos;
    logic [icmn_pkg::MEAN_W-1:0] mean_sel, ch_mean;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign cur_row = i_frame_start ? '0 : r_row;
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_ch  = i_frame_start ? '0 : r_ch;

    assign row_d = DW'(cur_row) - DW'(i_cfg.row_off);
    assign col_d = DW'(cur_col) - DW'(i_cfg.col_off);
    assign row_hit = !row_d[DW-1] && (row_d[DW-2:0] < (DW-1)'(i_cfg.height));
    assign col_hit = !col_d[DW-1] && (col_d[DW-2:0] < (DW-1)'(i_cfg.width));

    assign w_pos = col_d[icmn_pkg::CROP_W-1:0];

    always_comb begin
        case (cur_ch)
            2'd0:    ch_mean = i_cfg.means[15:0];
            2'd1:    ch_mean = i_cfg.means[31:16];
            2'd2:    ch_mean = i_cfg.means[47:32];
            default: ch_mean = '0;
        endcase
        case (i_cfg.mean_mode)
            icmn_pkg::MEAN_CHANNEL: mean_sel = ch_mean;
            icmn_pkg::MEAN_ELEMENT: mean_sel = i_pixel_mean;
            default:                mean_sel = '0;
        endcase
    end

    assign o_push        = accept && row_hit && col_hit;
    assign o_entry.pixel = i_pixel;
    assign o_entry.mean  = mean_sel;
    assign o_entry.ch    = cur_ch;
    assign o_entry.row   = row_d[icmn_pkg::CROP_W-1:0];
    assign o_entry.col   = i_cfg.mirror ? (i_cfg.width - 9'd1 - w_pos) : w_pos;

    assign ch_inc = cur_ch + 2'd1;

    always_comb begin
        n_row = cur_row;
        n_col = cur_col;
        n_ch  = ch_inc;
        if (i_row_end) begin
            n_col = '0;
            n_ch  = '0;
            n_row = (cur_row == CW'(MAX_IMAGE - 1)) ? '0 : cur_row + 1'b1;
        end else if (ch_inc >= icmn_pkg::CH_W'(CHANNELS)) begin
            n_ch  = '0;
            n_col = (cur_col == CW'(MAX_IMAGE - 1)) ? '0 : cur_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_ch  <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
            r_ch  <= n_ch;
        end
    end

endmodule

### rtl/core/icmn_fifo.sv
// Short first-in first-out queue of classified pixels between front and back.
// Depends on icmn_pkg for the entry type.
module icmn_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  icmn_pkg::t_entry i_data,
    input  logic             i_pop,
    output icmn_pkg::t_entry o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    icmn_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/icmn_back.sv
// Back part: three-stage pipeline computing the planar index and the rounded,
// saturated Q15.16 value. Depends on icmn_pkg and the assertion macro header.
`include "image_crop_mirror_normalize_unit_assert.svh"

module icmn_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  icmn_pkg::t_cfg              i_cfg,
    input  logic                        i_empty,
    input  icmn_pkg::t_entry            i_data,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [icmn_pkg::IDX_W-1:0]  o_index,
    output logic [icmn_pkg::VAL_W-1:0]  o_value
);

    logic en;
    logic r_v1, r_v2, r_out_valid;

    logic [10:0] r_plane;
    logic [icmn_pkg::CROP_W-1:0] r_col1;
    logic signed [16:0] r_diff;
    logic [icmn_pkg::IDX_W-1:0] r_idx2;
    logic signed [41:0] r_prod;
    logic [icmn_pkg::IDX_W-1:0] r_index;
    logic [icmn_pkg::VAL_W-1:0] r_value;

    logic [10:0] plane;
    logic signed [16:0] diff;
    logic [19:0] idx_full;
    logic signed [41:0] prod, rnd;
    logic [33:0] shifted;
    logic [icmn_pkg::VAL_W-1:0] sat;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    assign plane = 11'(i_data.ch) * 11'(i_cfg.height) + 11'(i_data.row);
    assign diff  = $signed({1'b0, i_data.pixel, 8'd0}) - $signed({1'b0, i_data.mean});

    assign idx_full = 20'(r_plane) * 20'(i_cfg.width) + 20'(r_col1);
    assign prod     = 42'(r_diff) * 42'($signed({1'b0, i_cfg.scale}));

    assign rnd     = r_prod + 42'sd128;
    assign shifted = rnd[41:8];

    always_comb begin
        if (shifted[33:31] == 3'b000 || shifted[33:31] == 3'b111) begin
            sat = shifted[31:0];
        end else if (shifted[33]) begin
            sat = 32'h8000_0000;
        end else begin
            sat = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= !i_empty;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_plane <= plane;
            r_col1  <= i_data.col;
            r_diff  <= diff;
            r_idx2  <= idx_full[icmn_pkg::IDX_W-1:0];
            r_prod  <= prod;
            r_index <= r_idx2;
            r_value <= sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_index = r_index;
    assign o_value = r_value;

    `ICMN_ASSERT_NEXT(a_stall_holds_s1, !en, $stable(r_v1))
    `ICMN_ASSERT_NEXT(a_stall_holds_s2, !en, $stable(r_v2) && $stable(r_out_valid))
    `ICMN_ASSERT_NOW(a_out_from_s2, $rose(r_out_valid), $past(r_v2))

endmodule

### rtl/core/image_crop_mirror_normalize_unit.sv
// Top level of the image crop, mirror and normalize unit: configuration
// registers and the front, queue and back parts. Depends on icmn_pkg.
//
// Usage: pixel bytes arrive in HWC order on the s_axis channel, one transfer
// per byte; tuser marks the first byte of a frame and tlast the last byte of
// a source row. Bytes inside the crop window produce one m_axis transfer each
// carrying the planar CHW index and the normalized signed Q15.16 value; bytes
// outside the window produce nothing.
// Throughput is one byte per cycle while the queue is not full. A kept byte
// is written into the four-entry queue, then leaves it with the plane
// multiply, passes the index and value multiplies, and is rounded into the
// output register before it shows up on m_axis.
// When the receiver stalls, the back pipeline holds, the queue fills, and
// s_axis_tready drops once four kept bytes wait; dropped bytes are still
// taken while the queue has room.
// Reset (synchronous, active low) empties the queue and the pipeline, clears
// the row, column and channel counters and loads the register defaults.
// Configuration registers are written via i_cfg_we, i_cfg_index, i_cfg_data;
// the user must write only with no transfer in flight; the block does not check.
module image_crop_mirror_normalize_unit #(
    parameter int CHANNELS  = 3,
    parameter int MAX_CROP  = 256,
    parameter int MAX_IMAGE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel [7:0], pixel_mean [23:8]
    input  logic        s_axis_tuser,   // frame_start
    input  logic        s_axis_tlast,   // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // out_index [17:0], out_value [49:18], zero pad
);

    localparam int QUEUE_DEPTH = 4;

    logic [icmn_pkg::CROP_W-1:0]  r_height, r_width;
    logic [icmn_pkg::OFF_W-1:0]   r_row_off, r_col_off;
    logic                         r_mirror;
    logic [icmn_pkg::MODE_W-1:0]  r_mean_mode;
    logic [icmn_pkg::SCALE_W-1:0] r_scale;
    logic [icmn_pkg::MEANS_W-1:0] r_means;

    icmn_pkg::t_cfg   cfg;
    icmn_pkg::t_entry push_entry, pop_entry;
    logic push, pop, full, empty;
    logic [icmn_pkg::IDX_W-1:0] out_index;
    logic [icmn_pkg::VAL_W-1:0] out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height    <= 9'd224;
            r_width     <= 9'd224;
            r_row_off   <= '0;
            r_col_off   <= '0;
            r_mirror    <= 1'b0;
            r_mean_mode <= icmn_pkg::MEAN_NONE;
            r_scale     <= 24'd65536;
            r_means     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icmn_pkg::REG_CROP_HEIGHT:   r_height    <= i_cfg_data[8:0];
                icmn_pkg::REG_CROP_WIDTH:    r_width     <= i_cfg_data[8:0];
                icmn_pkg::REG_ROW_OFFSET:    r_row_off   <= i_cfg_data[9:0];
                icmn_pkg::REG_COL_OFFSET:    r_col_off   <= i_cfg_data[9:0];
                icmn_pkg::REG_MIRROR:        r_mirror    <= i_cfg_data[0];
                icmn_pkg::REG_MEAN_MODE:     r_mean_mode <= i_cfg_data[1:0];
                icmn_pkg::REG_SCALE:         r_scale     <= i_cfg_data[23:0];
                icmn_pkg::REG_CHANNEL_MEANS: r_means     <= i_cfg_data;
                default:                     r_means     <= r_means;
            endcase
        end
    end

    assign cfg.height    = ({2'b00, r_height} > 11'(MAX_CROP)) ? 9'(MAX_CROP) : r_height;
    assign cfg.width     = ({2'b00, r_width} > 11'(MAX_CROP)) ? 9'(MAX_CROP) : r_width;
    assign cfg.row_off   = r_row_off;
    assign cfg.col_off   = r_col_off;
    assign cfg.mirror    = r_mirror;
    assign cfg.mean_mode = r_mean_mode;
    assign cfg.scale     = r_scale;
    assign cfg.means     = r_means;

    icmn_front #(
        .CHANNELS  (CHANNELS),
        .MAX_IMAGE (MAX_IMAGE)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_pixel        (s_axis_tdata[7:0]),
        .i_frame_start  (s_axis_tuser),
        .i_row_end      (s_axis_tlast),
        .i_pixel_mean   (s_axis_tdata[23:8]),
        .i_full         (full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    icmn_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_full  (full),
        .o_empty (empty)
    );

    icmn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_empty (empty),
        .i_data  (pop_entry),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_index (out_index),
        .o_value (out_value)
    );

    assign m_axis_tdata = {6'd0, out_value, out_index};

endmodule
